FILE: rtl/core/framed_byte_receiver_checksum_defines.svh
// Assertion macros used by the receiver back end.
`ifndef FRAMED_BYTE_RECEIVER_CHECKSUM_DEFINES_SVH
`define FRAMED_BYTE_RECEIVER_CHECKSUM_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define FBRC_ASSERT_ALWAYS(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("fbrc invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define FBRC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fbrc implication violated");

`endif

FILE: rtl/core/fbrc_pkg.sv
// Shared types and constants of the framed byte receiver.
package fbrc_pkg;

    localparam int DEF_BUFFER_DEPTH = 64;
    localparam int BYTE_W           = 8;
    localparam int RIDX_W           = 6;

    localparam logic [7:0] HDR_FIRST  = 8'hFE;
    localparam logic [7:0] HDR_SECOND = 8'hEF;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    typedef enum logic [1:0] {
        FUNC_RX      = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_REJECT = 2'd2
    } ev_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        func_t                 kind;
        logic [BYTE_W-1:0]     rx_byte;
        logic                  is_hdr_first;
        logic                  is_hdr_second;
        logic [RIDX_W-1:0]     read_index;
        logic                  read_in_range;
    } item_t;

    typedef struct packed {
        ev_t               ev;
        logic              ready;
        logic [BYTE_W-1:0] data;
    } result_t;

endpackage

FILE: rtl/core/framed_byte_receiver_checksum.sv
// Top level of the framed byte receiver with additive checksum.
//
//  Channel   Role    Accept when             Carries
//  s_*       input   s_tvalid & s_tready     func, rx_byte, read_index
//  m_*       output  m_tvalid & m_tready     event_res, frame_ready, read_data
//
// Receive, release and unused items are answered from S_IDLE; a buffer read goes through
// S_READ and S_EMIT. A closing byte with length L goes through S_SUM and S_EMIT: entries
// 3..L+2 are summed one per cycle through the single read port of the buffer memory.
// Reset clears control state, the three header entries and the per-entry valid bits at once.
// A two-entry queue lets input transfers run ahead of the back end; the output register
// holds a result until it is taken and the back end waits on it.
module framed_byte_receiver_checksum #(
    parameter int BUFFER_DEPTH = fbrc_pkg::DEF_BUFFER_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte [7:0], read_index [13:8], zero [15:14]
    input  logic [1:0]  s_tuser,   // func [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // frame_ready [0], read_data [8:1], zero [15:9]
    output logic [1:0]  m_tuser    // event_res [1:0]
);
    import fbrc_pkg::*;

    logic    q_valid;
    logic    q_pop;
    item_t   q_item;
    result_t res;

    fbrc_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    fbrc_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res      (res)
    );

    assign m_tdata = {7'd0, res.data, res.ready};
    assign m_tuser = res.ev;

endmodule

FILE: rtl/core/fbrc_front.sv
// Front end: accepts input transfers, classifies them and queues them for the back end.
module fbrc_front #(
    parameter int BUFFER_DEPTH = fbrc_pkg::DEF_BUFFER_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [15:0]     s_tdata,   // rx_byte [7:0], read_index [13:8], zero [15:14]
    input  logic [1:0]      s_tuser,   // func [1:0]
    output logic            q_valid,
    input  logic            q_pop,
    output fbrc_pkg::item_t q_item
);
    import fbrc_pkg::*;

    localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       in_item;
    logic        push;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        in_item               = '0;
        in_item.kind          = func_t'(s_tuser);
        in_item.rx_byte       = s_tdata[7:0];
        in_item.is_hdr_first  = (s_tdata[7:0] == HDR_FIRST);
        in_item.is_hdr_second = (s_tdata[7:0] == HDR_SECOND);
        in_item.read_index    = s_tdata[13:8];
        in_item.read_in_range = (8'(s_tdata[13:8]) < DEPTH_B);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/fbrc_back.sv
// Back end: frame tracking, buffer memory, checksum walk and output register.
`include "framed_byte_receiver_checksum_defines.svh"

module fbrc_back #(
    parameter int BUFFER_DEPTH = fbrc_pkg::DEF_BUFFER_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  fbrc_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output fbrc_pkg::result_t res
);
    import fbrc_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(BUFFER_DEPTH);
    localparam logic [7:0]     DEPTH_B = 8'(BUFFER_DEPTH);

    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_LOW  = 2'd1;
    localparam logic [1:0] SRC_MEM  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic              saw_reg, saw_next;
    logic              inf_reg, inf_next;
    logic              done_reg, done_next;
    logic [7:0]        e_reg [3];
    logic [7:0]        e_next [3];
    logic [7:0]        acc_reg, acc_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  end_reg, end_next;
    logic              pend_reg, pend_next;
    logic [1:0]        src_reg, src_next;
    logic [1:0]        lo_reg, lo_next;
    ev_t               ev_reg, ev_next;
    logic [7:0]        data_reg, data_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    // Entries 0..2 live in flops; the rest in the memory with per-entry valid bits
    logic [7:0]              mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] vld_reg;
    logic [7:0]              mem_q;
    logic                    vld_q;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [7:0]        mem_wd;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [7:0]        mem_val;
    logic [7:0]        rd_val;
    logic              slot_free;
    logic              issue;
    logic [7:0]        rd_wide;
    logic [7:0]        len;
    logic [8:0]        last9;
    logic [IDX_W:0]    widx_inc;
    logic              chk;

    assign slot_free = !out_valid_reg || m_tready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && slot_free;
    assign issue     = (addr_reg <= end_reg);
    assign mem_val   = vld_q ? mem_q : 8'd0;
    assign m_tvalid  = out_valid_reg;
    assign res       = out_reg;
    assign rd_wide   = 8'(q_item.read_index);

    always_comb
    begin
        case (src_reg)
            SRC_LOW: rd_val = e_reg[lo_reg];
            SRC_MEM: rd_val = mem_val;
            default: rd_val = 8'd0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        saw_next       = saw_reg;
        inf_next       = inf_reg;
        done_next      = done_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        addr_next      = addr_reg;
        end_next       = end_reg;
        pend_next      = 1'b0;
        src_next       = src_reg;
        lo_next        = lo_reg;
        ev_next        = ev_reg;
        data_next      = data_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_wa         = widx_reg;
        mem_wd         = q_item.rx_byte;
        rd_en          = 1'b0;
        rd_idx         = addr_reg;
        len            = 8'd0;
        last9          = 9'd0;
        widx_inc       = '0;
        chk            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_item.kind)
                        FUNC_RX:
                        begin
                            if (!done_reg)
                            begin
                                if (widx_reg < IDX_W'(3))
                                begin
                                    e_next[widx_reg[1:0]] = q_item.rx_byte;
                                end
                                else
                                begin
                                    mem_we = 1'b1;
                                end
                                if (q_item.is_hdr_first)
                                begin
                                    saw_next = 1'b1;
                                end
                                else if (q_item.is_hdr_second)
                                begin
                                    // header complete: rewind and preset the length entry
                                    if (saw_reg)
                                    begin
                                        saw_next  = 1'b0;
                                        inf_next  = 1'b1;
                                        e_next[0] = HDR_FIRST;
                                        e_next[1] = HDR_SECOND;
                                        e_next[2] = DEPTH_B;
                                        widx_next = IDX_W'(1);
                                    end
                                end
                                else
                                begin
                                    saw_next = 1'b0;
                                end
                            end
                            len   = e_next[2];
                            last9 = {1'b0, len} + 9'd2;
                            chk   = inf_next && (9'(widx_next) > last9);
                            if (chk)
                            begin
                                // close one byte late: sum entries 0..len+2
                                saw_next   = 1'b0;
                                inf_next   = 1'b0;
                                widx_next  = IDX_W'(1);
                                acc_next   = e_next[0] + e_next[1] + e_next[2];
                                addr_next  = IDX_W'(3);
                                end_next   = last9[IDX_W-1:0];
                                state_next = S_SUM;
                            end
                            else
                            begin
                                widx_inc = {1'b0, widx_next} + 1'b1;
                                if (widx_inc >= DEPTH_W)
                                begin
                                    widx_next = '0;
                                end
                                else
                                begin
                                    widx_next = widx_inc[IDX_W-1:0];
                                end
                                out_next       = '{ev: EV_NONE, ready: done_reg, data: 8'd0};
                                out_valid_next = 1'b1;
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            done_next      = 1'b0;
                            out_next       = '{ev: EV_NONE, ready: 1'b0, data: 8'd0};
                            out_valid_next = 1'b1;
                        end
                        FUNC_READ:
                        begin
                            if (!q_item.read_in_range)
                            begin
                                src_next = SRC_ZERO;
                            end
                            else if (rd_wide < 8'd3)
                            begin
                                src_next = SRC_LOW;
                                lo_next  = rd_wide[1:0];
                            end
                            else
                            begin
                                src_next = SRC_MEM;
                                rd_en    = 1'b1;
                                rd_idx   = rd_wide[IDX_W-1:0];
                            end
                            state_next = S_READ;
                        end
                        default:
                        begin
                            out_next       = '{ev: EV_NONE, ready: done_reg, data: 8'd0};
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SUM:
            begin
                if (issue)
                begin
                    rd_en     = 1'b1;
                    rd_idx    = addr_reg;
                    addr_next = addr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    acc_next = acc_reg + mem_val;
                end
                if (!issue && !pend_reg)
                begin
                    data_next = 8'd0;
                    if (acc_reg == SUM_GOOD)
                    begin
                        done_next = 1'b1;
                        ev_next   = EV_ACCEPT;
                    end
                    else
                    begin
                        ev_next = EV_REJECT;
                    end
                    state_next = S_EMIT;
                end
            end
            S_READ:
            begin
                ev_next    = EV_NONE;
                data_next  = rd_val;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_next       = '{ev: ev_reg, ready: done_reg, data: data_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_idx];
            vld_q <= vld_reg[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        addr_reg <= addr_next;
        end_reg  <= end_next;
        lo_reg   <= lo_next;
        ev_reg   <= ev_next;
        data_reg <= data_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            widx_reg      <= '0;
            saw_reg       <= 1'b0;
            inf_reg       <= 1'b0;
            done_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            src_reg       <= SRC_ZERO;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                e_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            saw_reg       <= saw_next;
            inf_reg       <= inf_next;
            done_reg      <= done_next;
            pend_reg      <= pend_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
            e_reg         <= e_next;
            if (mem_we)
            begin
                vld_reg[mem_wa] <= 1'b1;
            end
        end
    end

    `FBRC_ASSERT_ALWAYS(a_done_outside_frame, clk, rst_n, !(done_reg && inf_reg))
    `FBRC_ASSERT_ALWAYS(a_widx_in_range, clk, rst_n, 9'(widx_reg) < 9'(BUFFER_DEPTH))
    `FBRC_ASSERT_IMP(a_sum_frame_closed, clk, rst_n, state_reg == S_SUM, !inf_reg && !saw_reg)
    `FBRC_ASSERT_IMP(a_sum_addr_in_range, clk, rst_n, (state_reg == S_SUM) && issue, 9'(addr_reg) < 9'(BUFFER_DEPTH))

endmodule
